/* src/ldf_pkg.sv */
// shared types and constants for the length-prefixed deframer
`timescale 1ns / 1ps

package ldf_pkg;

  localparam int unsigned LENGTH_BITS   = 31;
  localparam int unsigned HEADER_BYTES  = 8;
  localparam int unsigned HDR_IDX_W     = $clog2(HEADER_BYTES);
  localparam int unsigned MAGIC_W       = 32;
  localparam int unsigned MAX_LEN_W     = 31;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [MAGIC_W-1:0]   MAGIC_RESET   = 32'h6D42_6454;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 31'd1048576;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'd1;

  typedef enum logic [1:0] {
    ST_PAYLOAD    = 2'd0,
    ST_BAD_MAGIC  = 2'd1,
    ST_BAD_LENGTH = 2'd2
  } ldf_status_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    logic        last;
    ldf_status_e status;
  } ldf_result_t;

endpackage

/* src/ldf_parser.sv */
// header parser and payload counter of the deframer
`timescale 1ns / 1ps

module ldf_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [7:0]                    byte_i,
  input  logic [ldf_pkg::MAGIC_W-1:0]   magic_i,
  input  logic [ldf_pkg::MAX_LEN_W-1:0] max_len_i,
  output ldf_pkg::ldf_result_t          result_o
);
  import ldf_pkg::*;

  localparam int unsigned SHIFT_W = (HEADER_BYTES - 1) * 8;

  logic                   in_payload_q, in_payload_d;
  logic [HDR_IDX_W-1:0]   hdr_idx_q, hdr_idx_d;
  logic [SHIFT_W-1:0]     hdr_shift_q, hdr_shift_d;
  logic [LENGTH_BITS-1:0] bytes_left_q, bytes_left_d;

  logic [63:0] hdr_full;
  logic [31:0] got_magic;
  logic [31:0] got_len;
  logic        hdr_done;
  logic        bad_magic;
  logic        bad_len;
  logic        last_byte;

  assign hdr_full  = {hdr_shift_q, byte_i};
  assign got_magic = hdr_full[63:32];
  assign got_len   = hdr_full[31:0];
  assign hdr_done  = (hdr_idx_q == HDR_IDX_W'(HEADER_BYTES - 1));
  assign bad_magic = (got_magic != magic_i);
  // zero, negative, too big for the counter, or above the limit
  assign bad_len   = (got_len == 32'd0) || got_len[31]
                   || ((got_len >> LENGTH_BITS) != 32'd0)
                   || (got_len > {1'b0, max_len_i});
  assign last_byte = (bytes_left_q <= LENGTH_BITS'(1));

  always_comb begin
    result_o        = '0;
    result_o.status = ST_PAYLOAD;
    if (in_payload_q) begin
      result_o.valid = 1'b1;
      result_o.data  = byte_i;
      result_o.last  = last_byte;
    end else if (hdr_done) begin
      if (bad_magic) begin
        result_o.valid  = 1'b1;
        result_o.status = ST_BAD_MAGIC;
      end else if (bad_len) begin
        result_o.valid  = 1'b1;
        result_o.status = ST_BAD_LENGTH;
      end
    end
  end

  always_comb begin
    in_payload_d = in_payload_q;
    hdr_idx_d    = hdr_idx_q;
    hdr_shift_d  = hdr_shift_q;
    bytes_left_d = bytes_left_q;
    if (in_payload_q) begin
      if (last_byte) begin
        in_payload_d = 1'b0;
        bytes_left_d = '0;
        hdr_idx_d    = '0;
      end else begin
        bytes_left_d = bytes_left_q - LENGTH_BITS'(1);
      end
    end else begin
      hdr_shift_d = hdr_full[SHIFT_W-1:0];
      if (hdr_done) begin
        hdr_idx_d = '0;
        if (!bad_magic && !bad_len) begin
          in_payload_d = 1'b1;
          bytes_left_d = got_len[LENGTH_BITS-1:0];
        end
      end else begin
        hdr_idx_d = hdr_idx_q + HDR_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_idx_q    <= '0;
      hdr_shift_q  <= '0;
      bytes_left_q <= '0;
    end else if (step_i) begin
      in_payload_q <= in_payload_d;
      hdr_idx_q    <= hdr_idx_d;
      hdr_shift_q  <= hdr_shift_d;
      bytes_left_q <= bytes_left_d;
    end
  end

  a_payload_has_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (bytes_left_q != '0) && (hdr_idx_q == '0))
    else $error("payload phase with empty count or mid-header index");

  a_last_leaves_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && in_payload_q && last_byte |=> !in_payload_q)
    else $error("frame did not end after its last byte");

endmodule

/* src/length_prefixed_deframer_unit.sv */
// top level of the length-prefixed deframer with magic header check
`timescale 1ns / 1ps

// byte-serial deframer: each frame is an 8-byte header (4-byte magic word,
// then a 4-byte big-endian signed length) followed by that many payload
// bytes. every payload byte leaves as one output transfer with status
// payload, the final one with tlast set. after the eighth header byte a bad
// magic word, or failing that a length that is zero, negative or above
// max_length, gives one error transfer with zero data, and parsing restarts
// with the very next byte. a good header gives no output. the block takes
// one byte per cycle while the output is not stalled; each byte is held in the
// input register and its result then in the result register, from which it
// leaves. the rate is set by the update loop of the header index and payload
// counter. write configuration only while the block is idle

module length_prefixed_deframer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,   // [7:0] rx_byte
  // output stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [7:0]                     m_axis_tdata_o,   // [7:0] payload_byte
  output logic                           m_axis_tlast_o,   // frame_end
  output logic [1:0]                     m_axis_tuser_o,   // [1:0] status
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [ldf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ldf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ldf_pkg::*;

  // configuration registers
  logic [MAGIC_W-1:0]   magic_q;
  logic [MAX_LEN_W-1:0] max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= MAGIC_RESET;
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAGIC:   magic_q   <= cfg_data_i[MAGIC_W-1:0];
        REG_MAX_LEN: max_len_q <= cfg_data_i[MAX_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // result register stage
  logic        out_vld_q;
  logic [7:0]  out_data_q;
  logic        out_last_q;
  ldf_status_e out_status_q;

  ldf_result_t res;
  logic        out_free;
  logic        advance;
  logic        in_take;
  logic        out_load;

  // output slot is free if empty or being drained this cycle
  assign out_free = !out_vld_q || m_axis_tready_i;
  // a byte leaves the input stage when it makes no result or the slot is free
  assign advance  = in_vld_q && (!res.valid || out_free);
  assign out_load = advance && res.valid;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;

  ldf_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .magic_i   (magic_q),
    .max_len_i (max_len_q),
    .result_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (out_load) begin
      out_data_q   <= res.data;
      out_last_q   <= res.last;
      out_status_q <= res.status;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_status_q;

  a_error_is_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_status_q != ST_PAYLOAD) |-> (out_data_q == 8'd0) && !out_last_q)
    else $error("error transfer carries data or end mark");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register overwritten before transfer");

  a_stalled_byte_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_byte_q))
    else $error("stalled input byte lost");

endmodule

/* verif/testbench.sv */
// self-checking testbench for the length-prefixed deframer unit
`timescale 1ns / 1ps

module testbench;
  import ldf_pkg::*;

  // one predicted output transfer
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    ldf_status_e status;
  } deframe_out_t;

  // scoreboard: tracks the deframer state on every accepted input byte and
  // queues the transfers that byte should produce, oldest first
  class deframe_scoreboard;
    logic [31:0]  magic_word;
    logic [30:0]  max_len;
    bit           in_payload;
    logic [2:0]   hdr_idx;
    logic [63:0]  hdr_shift;
    logic [30:0]  bytes_left;
    deframe_out_t out_q[$];
    int           errors;

    function new();
      magic_word = MAGIC_RESET;
      max_len    = MAX_LEN_RESET;
      in_payload = 1'b0;
      hdr_idx    = '0;
      hdr_shift  = '0;
      bytes_left = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_MAGIC) begin
        magic_word = data;
      end else if (idx == REG_MAX_LEN) begin
        max_len = data[30:0];
      end
    endfunction

    function void note_rx_byte(logic [7:0] b);
      logic        fin;
      logic [31:0] len;
      if (in_payload) begin
        fin = (bytes_left <= 31'd1);
        out_q.push_back('{data: b, last: fin, status: ST_PAYLOAD});
        if (fin) begin
          in_payload = 1'b0;
          bytes_left = '0;
          hdr_idx    = '0;
        end else begin
          bytes_left = bytes_left - 31'd1;
        end
        return;
      end
      hdr_shift = {hdr_shift[55:0], b};
      if (hdr_idx != 3'd7) begin
        hdr_idx = hdr_idx + 3'd1;
        return;
      end
      hdr_idx = '0;
      len = hdr_shift[31:0];
      // magic takes priority over any length fault
      if (hdr_shift[63:32] != magic_word) begin
        out_q.push_back('{data: 8'h00, last: 1'b0, status: ST_BAD_MAGIC});
      end else if (len == 32'd0 || len[31] || len > {1'b0, max_len}) begin
        out_q.push_back('{data: 8'h00, last: 1'b0, status: ST_BAD_LENGTH});
      end else begin
        in_payload = 1'b1;
        bytes_left = len[30:0];
      end
    endfunction

    function void check_out_transfer(logic [7:0] data, logic last, logic [1:0] st);
      deframe_out_t want;
      if (out_q.size() == 0) begin
        $display("%0t: unexpected transfer data %h last %b status %0d",
                 $time, data, last, st);
        errors++;
        return;
      end
      want = out_q.pop_front();
      if (want.data != data || want.last != last || want.status != st) begin
        $display({"%0t: mismatch, expected data %h last %b status %0d,",
                  " got data %h last %b status %0d"},
                 $time, want.data, want.last, want.status, data, last, st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_tvalid = 1'b0;
  logic [7:0]            s_tdata  = '0;
  logic                  m_tready = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = REG_MAGIC;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  s_tready;
  logic                  m_tvalid;
  logic [7:0]            m_tdata;
  logic                  m_tlast;
  logic [1:0]            m_tuser;

  // set during one phase: neither side idles at all
  bit steady = 1'b0;
  int sent_bytes = 0;

  deframe_scoreboard sb = new();

  length_prefixed_deframer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sends one byte with a random gap in front; returns at the edge of the
  // transfer, leaving tvalid high so back-to-back bytes need no gap
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_rx_byte(b);
    sent_bytes++;
  endtask

  // header: magic word then length, both most significant byte first
  task automatic send_header(input logic [31:0] magic, input logic [31:0] len);
    for (int i = 3; i >= 0; i--) send_byte(magic[8*i +: 8]);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
  endtask

  // header plus random payload for as long as the header opened a frame
  task automatic run_frame(input logic [31:0] magic, input logic [31:0] len);
    send_header(magic, len);
    while (sb.in_payload) send_byte($urandom_range(255));
  endtask

  // pad with random bytes until the parser sits at a header boundary again
  task automatic realign();
    while (sb.in_payload || sb.hdr_idx != 3'd0) send_byte($urandom_range(255));
  endtask

  // drop tvalid and let every queued transfer drain, plus the pipeline depth
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.out_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // both registers, one per cycle; the spare top bit of max_length is random
  task automatic write_cfg(input logic [31:0] magic, input logic [30:0] max_len);
    logic [CFG_DATA_W-1:0] len_word;
    len_word = {1'($urandom_range(1)), max_len};
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_MAGIC;
    cfg_data <= magic;
    sb.set_reg(REG_MAGIC, magic);
    @(posedge clk_i);
    cfg_idx  <= REG_MAX_LEN;
    cfg_data <= len_word;
    sb.set_reg(REG_MAX_LEN, len_word);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly short payloads, now and then a longer one, never above a nonzero limit
  function automatic logic [31:0] good_len();
    logic [31:0] cap;
    cap = ($urandom_range(19) == 0) ? 32'd200 : 32'd16;
    if (sb.max_len != 31'd0 && {1'b0, sb.max_len} < cap) cap = {1'b0, sb.max_len};
    return $urandom_range(cap, 1);
  endfunction

  // zero, negative, just above the limit, or all ones
  function automatic logic [31:0] bad_len();
    logic [31:0] len;
    case ($urandom_range(3))
      0:       len = 32'd0;
      1:       len = {1'b1, 31'($urandom)};
      2:       len = {1'b0, sb.max_len} + 32'd1 + $urandom_range(3);
      default: len = 32'hFFFF_FFFF;
    endcase
    return len;
  endfunction

  // output side: check at each transfer edge, then pick the next tready
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_tvalid && m_tready) sb.check_out_transfer(m_tdata, m_tlast, m_tuser);
      m_tready <= steady || ($urandom_range(99) >= 14);
    end
  end

  // stimulus
  initial begin
    logic [31:0] magic_set [6];
    logic [30:0] max_set   [6];
    logic [31:0] cur_magic;
    logic [31:0] flip;
    int          target;
    int          pick;

    // settings per phase, the register extremes among them
    magic_set[0] = 32'h0000_0000;  max_set[0] = 31'd1;
    magic_set[1] = 32'hFFFF_FFFF;  max_set[1] = 31'h7FFF_FFFF;
    magic_set[2] = $urandom;       max_set[2] = 31'($urandom_range(64, 1));
    magic_set[3] = MAGIC_RESET;    max_set[3] = 31'd0;
    magic_set[4] = $urandom;       max_set[4] = 31'($urandom_range(32'h7FFF_FFFF, 1));
    magic_set[5] = $urandom;       max_set[5] = 31'd20;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under the reset settings
    send_header(MAGIC_RESET, 32'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    run_frame(MAGIC_RESET, 32'd1);
    send_header(~MAGIC_RESET, 32'd0);          // bad magic and bad length together
    send_header(MAGIC_RESET ^ 32'd1, 32'd5);   // bad magic, length fine
    send_header(MAGIC_RESET, 32'd0);           // zero length
    send_header(MAGIC_RESET, 32'h8000_0000);   // negative length
    send_header(MAGIC_RESET, {1'b0, MAX_LEN_RESET} + 32'd1);
    send_header(MAGIC_RESET, 32'h7FFF_FFFF);
    settle();

    // random phases, one per register setting
    for (int p = 0; p < 6; p++) begin
      write_cfg(magic_set[p], max_set[p]);
      steady    = (p == 2);
      cur_magic = sb.magic_word;
      target    = sent_bytes + 255;
      while (sent_bytes < target) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          run_frame(cur_magic, good_len());
        end else if (pick < 80) begin
          run_frame(cur_magic, bad_len());
        end else if (pick < 88) begin
          flip = ($urandom_range(1) == 0) ? (32'd1 << $urandom_range(31)) : $urandom;
          if (flip == 32'd0) flip = 32'h8000_0000;
          run_frame(cur_magic ^ flip, ($urandom_range(1) == 0) ? good_len() : bad_len());
        end else begin
          // stray bytes that break the framing, then back to a boundary
          repeat ($urandom_range(7, 1)) send_byte($urandom_range(255));
          realign();
        end
      end
      realign();
      settle();
      steady = 1'b0;
    end

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
